[rtl/core/tes_pkg.sv]
// ----------------------------------------------------------------------------
// Text encoding sniffer package
// Encoding codes, register indexes and shared types for the sniffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

   localparam int unsigned EncWidth = 3;
   localparam int unsigned SkipWidth = 2;

   // Result encoding codes.
   localparam logic [EncWidth-1:0] ENC_ANSI      = 3'd0;
   localparam logic [EncWidth-1:0] ENC_UTF8      = 3'd1;
   localparam logic [EncWidth-1:0] ENC_UTF8_MARK = 3'd2;
   localparam logic [EncWidth-1:0] ENC_UTF16_LE  = 3'd3;
   localparam logic [EncWidth-1:0] ENC_UTF16_BE  = 3'd4;

   // Configuration register indexes.
   localparam logic CSR_AUTO_DETECT     = 1'b0;
   localparam logic CSR_PRESET_ENCODING = 1'b1;

   localparam logic [EncWidth-1:0] PRESET_RESET = ENC_UTF8_MARK;

   // Mark bytes.
   localparam logic [7:0] UTF8_MARK_0 = 8'hef;
   localparam logic [7:0] UTF8_MARK_1 = 8'hbb;
   localparam logic [7:0] UTF8_MARK_2 = 8'hbf;
   localparam logic [7:0] UTF16_FF    = 8'hff;
   localparam logic [7:0] UTF16_FE    = 8'hfe;

   // Selection handed from the scanner side to the result register.
   typedef struct packed {
      logic [EncWidth-1:0] det_code;
      logic                auto_detect;
      logic [EncWidth-1:0] preset;
   } tes_sel_type;

   function automatic logic [SkipWidth-1:0] mark_skip(input logic [EncWidth-1:0] code);
      logic [SkipWidth-1:0] skip;
      skip = 2'd0;
      if (code == ENC_UTF8_MARK) begin
         skip = 2'd3;
      end else if (code == ENC_UTF16_LE || code == ENC_UTF16_BE) begin
         skip = 2'd2;
      end
      return skip;
   endfunction

endpackage

`default_nettype wire

[rtl/core/tes_scan.sv]
// ----------------------------------------------------------------------------
// Sniffer byte scanner
// Keeps the head bytes and UTF-8 scan flags of the current file and works
// out the detected encoding including the byte being transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tes_scan import tes_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic [7:0]          data_byte,
   input  wire logic                last_byte,
   output logic      [EncWidth-1:0] det_code
);

   logic [1:0]  pos_ff,  pos_in,  pos_step;
   logic [23:0] head_ff, head_in, head_step;
   logic [1:0]  pend_ff, pend_in, pend_step;
   logic        bad_ff,  bad_in,  bad_step;
   logic        nu_ff,   nu_in,   nu_step;
   logic [7:0]  b0, b1, b2;

   always_comb begin
      pos_step  = pos_ff;
      head_step = head_ff;
      if (pos_ff != 2'd3) begin
         head_step = head_ff | (24'(data_byte) << {pos_ff, 3'b000});
         pos_step  = pos_ff + 2'd1;
      end

      pend_step = pend_ff;
      bad_step  = bad_ff;
      nu_step   = nu_ff;
      if (!nu_ff) begin
         if (pend_ff != 2'd0) begin
            if (data_byte[7:6] != 2'b10) begin
               bad_step = 1'b1;
            end
            pend_step = pend_ff - 2'd1;
            if (pend_step == 2'd0) begin
               if (bad_step) begin
                  nu_step = 1'b1;
               end
               bad_step = 1'b0;
            end
         end else if (data_byte[7]) begin
            if (data_byte[7:6] == 2'b10) begin
               nu_step = 1'b1;
            end else if (data_byte[7:5] == 3'b110) begin
               pend_step = 2'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
               pend_step = 2'd2;
            end else begin
               nu_step = 1'b1;
            end
         end
      end
   end

   // The end of a file returns every flag to its reset value.
   always_comb begin
      if (last_byte) begin
         pos_in  = 2'd0;
         head_in = 24'd0;
         pend_in = 2'd0;
         bad_in  = 1'b0;
         nu_in   = 1'b0;
      end else begin
         pos_in  = pos_step;
         head_in = head_step;
         pend_in = pend_step;
         bad_in  = bad_step;
         nu_in   = nu_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         head_ff <= 24'd0;
         pend_ff <= 2'd0;
         bad_ff  <= 1'b0;
         nu_ff   <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         head_ff <= head_in;
         pend_ff <= pend_in;
         bad_ff  <= bad_in;
         nu_ff   <= nu_in;
      end
   end

   assign b0 = head_step[7:0];
   assign b1 = head_step[15:8];
   assign b2 = head_step[23:16];

   always_comb begin
      if (b0 == UTF16_FF && b1 == UTF16_FE) begin
         det_code = ENC_UTF16_LE;
      end else if (b0 == UTF16_FE && b1 == UTF16_FF) begin
         det_code = ENC_UTF16_BE;
      end else if (b0 == UTF8_MARK_0 && b1 == UTF8_MARK_1 && b2 == UTF8_MARK_2) begin
         det_code = ENC_UTF8_MARK;
      end else if (nu_step) begin
         det_code = ENC_ANSI;
      end else begin
         det_code = ENC_UTF8;
      end
   end

   // Once the scan has failed, no sequence is left open.
   a_failed_closed: assert property (@(posedge clock) disable iff (reset)
      nu_ff |-> (pend_ff == 2'd0 && !bad_ff))
      else $error("scan failed with an open sequence");

   // A lead never opens more than two continuations.
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("continuation count out of range");

   // A transfer of the final byte starts a fresh file.
   a_clear_at_end: assert property (@(posedge clock) disable iff (reset)
      (accept && last_byte) |=> (pos_ff == 2'd0 && head_ff == 24'd0 && !nu_ff))
      else $error("file state not cleared at end of file");

endmodule

`default_nettype wire

[rtl/core/tes_result.sv]
// ----------------------------------------------------------------------------
// Sniffer result register
// Chooses the detected or preset code and holds it until it is transferred.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tes_result import tes_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire tes_sel_type          sel,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [EncWidth-1:0]  rsp_encoding,
   output logic      [SkipWidth-1:0] rsp_header_bytes
);

   logic                 valid_ff, valid_in;
   logic [EncWidth-1:0]  enc_ff, enc_in;
   logic [SkipWidth-1:0] skip_ff, skip_in;

   assign enc_in   = sel.auto_detect ? sel.det_code : sel.preset;
   assign skip_in  = mark_skip(enc_in);
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         enc_ff  <= enc_in;
         skip_ff <= skip_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_encoding     = enc_ff;
   assign rsp_header_bytes = skip_ff;

   // A held result is never overwritten by a new one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !(valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   // The skip count always matches the code it was loaded with.
   a_skip_matches: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (skip_ff == mark_skip(enc_ff)))
      else $error("header byte count does not match encoding");

endmodule

`default_nettype wire

[rtl/core/text_encoding_sniffer_unit.sv]
// ----------------------------------------------------------------------------
// Text encoding sniffer unit
// Detects UTF-16 and UTF-8 marks and checks UTF-8 validity of a byte stream.
// ----------------------------------------------------------------------------
// Usage: the bytes of a file arrive on the req_ channel, one per transfer,
// with req_last_byte set on the final byte. One result is given per file on
// the rsp_ channel: the encoding code and the number of mark bytes to skip.
// Bytes that are not the last one give no result.
// Throughput is one byte per cycle while req_stall is low. The result of a file
// appears on rsp_ in the cycle after its last byte is transferred; the
// scan flags and the head-byte register are updated in that same cycle.
// A result waits in the output register while rsp_stall is high; req_stall
// is raised only while such a result is held, and it is dropped in the cycle
// the result is taken, so the input keeps streaming.
// The csr_ port writes auto_detect (index 0) and preset_encoding (index 1);
// it should be written only between files.
// Reset clears the file state and the output valid flag, sets auto_detect to
// one and preset_encoding to the UTF-8-with-mark code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_encoding_sniffer_unit import tes_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_last_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [EncWidth-1:0]  rsp_encoding,
   output logic      [SkipWidth-1:0] rsp_header_bytes,
   input  wire logic                 csr_write_enable,
   input  wire logic                 csr_index,
   input  wire logic [EncWidth-1:0]  csr_write_data
);

   logic                auto_ff, auto_in;
   logic [EncWidth-1:0] preset_ff, preset_in;
   logic                accept;
   logic [EncWidth-1:0] det_code;
   tes_sel_type         sel;

   always_comb begin
      auto_in   = auto_ff;
      preset_in = preset_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_AUTO_DETECT:     auto_in   = csr_write_data[0];
            CSR_PRESET_ENCODING: preset_in = csr_write_data;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ff   <= 1'b1;
         preset_ff <= PRESET_RESET;
      end else begin
         auto_ff   <= auto_in;
         preset_ff <= preset_in;
      end
   end

   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   tes_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .det_code  (det_code)
   );

   assign sel.det_code    = det_code;
   assign sel.auto_detect = auto_ff;
   assign sel.preset      = preset_ff;

   tes_result u_result (
      .clock            (clock),
      .reset            (reset),
      .load             (accept & req_last_byte),
      .sel              (sel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_encoding     (rsp_encoding),
      .rsp_header_bytes (rsp_header_bytes)
   );

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Text encoding sniffer testbench
// Streams files byte by byte into the sniffer with random idling on both
// sides, predicts the encoding of every file and checks each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import tes_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } file_byte_type;

   typedef struct packed {
      logic [EncWidth-1:0]  encoding;
      logic [SkipWidth-1:0] header_bytes;
   } verdict_type;

   localparam int QuietLimit = 3000;
   localparam int LongHold = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [7:0]           req_data_byte = 8'h00;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [EncWidth-1:0]  rsp_encoding;
   logic [SkipWidth-1:0] rsp_header_bytes;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_index = CSR_AUTO_DETECT;
   logic [EncWidth-1:0]  csr_write_data = '0;

   file_byte_type byte_q[$];
   verdict_type   verdict_q[$];

   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  hold_requests = 0;
   int  hold_seen = 0;
   int  hold_left = 0;
   int  quiet_cycles = 0;
   int  mismatches = 0;
   logic in_taken = 1'b0;

   // Shadow of the sniffer registers and per-file scan state.
   logic                shadow_auto = 1'b1;
   logic [EncWidth-1:0] shadow_preset = ENC_UTF8_MARK;
   logic [7:0]          head_byte [3] = '{default: 8'h00};
   int                  seen_count = 0;
   logic [1:0]          cont_left = 2'd0;
   logic                cont_bad = 1'b0;
   logic                scan_failed = 1'b0;

   text_encoding_sniffer_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_encoding     (rsp_encoding),
      .rsp_header_bytes (rsp_header_bytes),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Updates the file state with one byte and queues the verdict on the last one.
   task automatic sniff_byte(input logic [7:0] b, input logic last);
      verdict_type v;
      logic [EncWidth-1:0] code;
      if (seen_count < 3) begin
         head_byte[seen_count] = b;
         seen_count++;
      end
      if (!scan_failed) begin
         if (cont_left != 2'd0) begin
            if ((b & 8'hc0) != 8'h80) begin
               cont_bad = 1'b1;
            end
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
               if (cont_bad) begin
                  scan_failed = 1'b1;
               end
               cont_bad = 1'b0;
            end
         end else if (b >= 8'h80) begin
            if (b < 8'hc0 || b >= 8'hf0) begin
               scan_failed = 1'b1;
            end else if (b < 8'he0) begin
               cont_left = 2'd1;
            end else begin
               cont_left = 2'd2;
            end
         end
      end
      if (last) begin
         if (!shadow_auto) begin
            code = shadow_preset;
         end else if (head_byte[0] == UTF16_FF && head_byte[1] == UTF16_FE) begin
            code = ENC_UTF16_LE;
         end else if (head_byte[0] == UTF16_FE && head_byte[1] == UTF16_FF) begin
            code = ENC_UTF16_BE;
         end else if (head_byte[0] == UTF8_MARK_0 && head_byte[1] == UTF8_MARK_1 &&
                      head_byte[2] == UTF8_MARK_2) begin
            code = ENC_UTF8_MARK;
         end else begin
            code = scan_failed ? ENC_ANSI : ENC_UTF8;
         end
         v.encoding = code;
         case (code)
            ENC_UTF8_MARK: v.header_bytes = 2'd3;
            ENC_UTF16_LE, ENC_UTF16_BE: v.header_bytes = 2'd2;
            default: v.header_bytes = 2'd0;
         endcase
         verdict_q.push_back(v);
         head_byte = '{default: 8'h00};
         seen_count = 0;
         cont_left = 2'd0;
         cont_bad = 1'b0;
         scan_failed = 1'b0;
      end
   endtask

   // Monitor: byte transfers feed the prediction, result transfers are checked.
   always @(posedge clock) begin : monitor
      verdict_type v;
      if (reset) begin
         in_taken <= 1'b0;
      end else begin
         in_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            sniff_byte(req_data_byte, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               report_mismatch($sformatf("result enc=%0d skip=%0d with no file pending",
                                         rsp_encoding, rsp_header_bytes));
            end else begin
               v = verdict_q.pop_front();
               if (rsp_encoding !== v.encoding) begin
                  report_mismatch($sformatf("encoding %0d, expected %0d",
                                            rsp_encoding, v.encoding));
               end
               if (rsp_header_bytes !== v.header_bytes) begin
                  report_mismatch($sformatf("header_bytes %0d, expected %0d",
                                            rsp_header_bytes, v.header_bytes));
               end
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QuietLimit) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // Byte driver: a new byte is offered only once the previous one has transferred.
   always @(negedge clock) begin : byte_driver
      file_byte_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
            nxt = byte_q.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= nxt.data;
            req_last_byte <= nxt.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls and a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LongHold;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   task automatic write_csr(input logic idx, input logic [EncWidth-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_AUTO_DETECT) begin
         shadow_auto = data[0];
      end else begin
         shadow_preset = data;
      end
   endtask

   // The auto_detect write carries random upper bits, which must be ignored.
   task automatic write_auto(input logic on);
      logic [EncWidth-2:0] junk;
      junk = (EncWidth-1)'($urandom_range(3));
      write_csr(CSR_AUTO_DETECT, {junk, on});
   endtask

   task automatic push_file(input logic [7:0] fb[$]);
      file_byte_type item;
      for (int i = 0; i < fb.size(); i++) begin
         item.data = fb[i];
         item.last = (i == fb.size() - 1);
         byte_q.push_back(item);
      end
   endtask

   function automatic logic [7:0] cont_byte();
      logic [5:0] low;
      low = 6'($urandom_range(63));
      return {2'b10, low};
   endfunction

   function automatic logic [7:0] broken_cont_byte();
      logic [7:0] b;
      b = $urandom_range(1) ? 8'($urandom_range(127)) : 8'($urandom_range(255, 192));
      return b;
   endfunction

   // Builds one file: an optional mark or near-mark, a body of UTF-8 sequences
   // with occasional faults, and sometimes a sequence cut off by the end.
   task automatic add_random_file(output int n);
      logic [7:0] fb[$];
      logic [7:0] b;
      int pick;
      int chunks;
      bit clean;
      pick = $urandom_range(99);
      if (pick < 10) begin
         fb = '{UTF16_FF, UTF16_FE};
      end else if (pick < 20) begin
         fb = '{UTF16_FE, UTF16_FF};
      end else if (pick < 32) begin
         fb = '{UTF8_MARK_0, UTF8_MARK_1, UTF8_MARK_2};
      end else if (pick < 38) begin
         b = 8'($urandom_range(255));
         fb = '{UTF8_MARK_0, UTF8_MARK_1, b};
      end else if (pick < 42) begin
         b = 8'($urandom_range(255));
         fb = '{UTF16_FE, b};
      end else if (pick < 45) begin
         b = 8'($urandom_range(255));
         fb = '{UTF16_FF, b};
      end
      chunks = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(6);
      clean = ($urandom_range(99) < 45);
      for (int c = 0; c < chunks; c++) begin
         pick = clean ? $urandom_range(74) : $urandom_range(99);
         if (pick < 35) begin
            b = 8'($urandom_range(127));
            fb.push_back(b);
         end else if (pick < 55) begin
            b = 8'($urandom_range(8'hdf, 8'hc0));
            fb.push_back(b);
            fb.push_back(cont_byte());
         end else if (pick < 75) begin
            b = 8'($urandom_range(8'hef, 8'he0));
            fb.push_back(b);
            fb.push_back(cont_byte());
            fb.push_back(cont_byte());
         end else if (pick < 80) begin
            b = 8'($urandom_range(8'hbf, 8'h80));
            fb.push_back(b);
         end else if (pick < 85) begin
            b = 8'($urandom_range(8'hff, 8'hf0));
            fb.push_back(b);
         end else if (pick < 90) begin
            b = 8'($urandom_range(8'hdf, 8'hc0));
            fb.push_back(b);
            fb.push_back(broken_cont_byte());
         end else if (pick < 95) begin
            b = 8'($urandom_range(8'hef, 8'he0));
            fb.push_back(b);
            if ($urandom_range(1)) begin
               fb.push_back(broken_cont_byte());
               fb.push_back(cont_byte());
            end else begin
               fb.push_back(cont_byte());
               fb.push_back(broken_cont_byte());
            end
         end else begin
            b = 8'($urandom_range(255));
            fb.push_back(b);
         end
      end
      if ($urandom_range(99) < 15) begin
         b = $urandom_range(1) ? 8'($urandom_range(8'hdf, 8'hc0))
                               : 8'($urandom_range(8'hef, 8'he0));
         fb.push_back(b);
         if (b >= 8'he0 && $urandom_range(1)) begin
            b = 8'($urandom_range(255));
            fb.push_back(b);
         end
      end
      if (fb.size() == 0) begin
         b = 8'($urandom_range(255));
         fb.push_back(b);
      end
      push_file(fb);
      n = fb.size();
   endtask

   // Waits until every byte has transferred and every result has arrived.
   task automatic settle();
      while (byte_q.size() != 0 || req_valid || verdict_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic stream_files(input int n_bytes);
      int pushed;
      int n;
      pushed = 0;
      while (pushed < n_bytes) begin
         add_random_file(n);
         pushed += n;
      end
      settle();
   endtask

   task automatic directed_files();
      logic [7:0] fb[$];
      fb = '{8'hff};                                push_file(fb);
      fb = '{8'h00};                                push_file(fb);
      fb = '{8'h7f};                                push_file(fb);
      fb = '{UTF16_FF, UTF16_FE};                   push_file(fb);
      fb = '{UTF16_FE, UTF16_FF};                   push_file(fb);
      fb = '{UTF16_FE, UTF16_FF, 8'h80};            push_file(fb);
      fb = '{UTF8_MARK_0, UTF8_MARK_1, UTF8_MARK_2}; push_file(fb);
      // Two-byte file: the third mark byte reads as zero, so no mark.
      fb = '{UTF8_MARK_0, UTF8_MARK_1};             push_file(fb);
      fb = '{8'h80};                                push_file(fb);
      fb = '{8'hc3, 8'ha9};                         push_file(fb);
      fb = '{8'hc3, 8'h41};                         push_file(fb);
      // A sequence cut off by the end is not checked.
      fb = '{8'he2, 8'h41};                         push_file(fb);
      settle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 32;
      rx_idle_pct = 58;
      write_auto(1'b1);
      write_csr(CSR_PRESET_ENCODING, ENC_UTF8_MARK);
      directed_files();
      stream_files(400);

      write_auto(1'b0);
      write_csr(CSR_PRESET_ENCODING, 3'd0);
      stream_files(40);

      tx_idle_pct = 58;
      rx_idle_pct = 32;
      write_csr(CSR_PRESET_ENCODING, 3'd7);
      stream_files(40);
      for (int p = 1; p < 7; p++) begin
         write_csr(CSR_PRESET_ENCODING, p[EncWidth-1:0]);
         stream_files(15);
      end

      write_auto(1'b1);
      write_csr(CSR_PRESET_ENCODING, 3'd5);
      // The receiver holds off while files keep arriving, so the sniffer fills.
      hold_requests++;
      stream_files(400);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      stream_files(200);
      write_auto(1'b0);
      write_csr(CSR_PRESET_ENCODING, ENC_UTF16_BE);
      stream_files(30);
      write_auto(1'b1);
      stream_files(150);

      repeat (5) @(posedge clock);
      if (verdict_q.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
      end
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/tes_pkg.sv
rtl/core/tes_scan.sv
rtl/core/tes_result.sv
rtl/core/text_encoding_sniffer_unit.sv
tb/testbench.sv
